>>> hw/rtl/gss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types, constants and helper functions for the gate safety supervisor.
// ----------------------------------------------------------------------------
package gss_pkg;

    // timer and register widths
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int TALLY_W    = 16;
    localparam int EV_W       = 7;
    localparam int IDX_W      = 3;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_W-1:0]      cfg_t;
    typedef logic [TALLY_W-1:0]    tally_t;
    typedef logic [EV_W-1:0]       event_t;
    typedef logic [IDX_W-1:0]      reg_idx_t;

    localparam tally_t TALLY_MAX = '1;

    // configuration register indexes
    localparam reg_idx_t REG_OBSTACLE_DB  = 3'd0;
    localparam reg_idx_t REG_LIMIT_DB     = 3'd1;
    localparam reg_idx_t REG_STOP_DB      = 3'd2;
    localparam reg_idx_t REG_OC_THRESHOLD = 3'd3;
    localparam reg_idx_t REG_OC_HOLD      = 3'd4;
    localparam reg_idx_t REG_WD_TIMEOUT   = 3'd5;

    // configuration reset values
    localparam cfg_t RST_OBSTACLE_DB  = 16'd30;
    localparam cfg_t RST_LIMIT_DB     = 16'd30;
    localparam cfg_t RST_STOP_DB      = 16'd30;
    localparam cfg_t RST_OC_THRESHOLD = 16'd10000;
    localparam cfg_t RST_OC_HOLD      = 16'd500;
    localparam cfg_t RST_WD_TIMEOUT   = 16'd5000;

    // event flag bit positions
    localparam int EV_OBS_ON  = 0;
    localparam int EV_OBS_OFF = 1;
    localparam int EV_OPEN    = 2;
    localparam int EV_CLOSE   = 3;
    localparam int EV_STOP    = 4;
    localparam int EV_SET     = 5;
    localparam int EV_CLEAR   = 6;

    typedef enum logic [2:0] {
        FAULT_NONE        = 3'd0,
        FAULT_OBSTACLE    = 3'd1,
        FAULT_LIMIT       = 3'd2,
        FAULT_TELEMETRY   = 3'd3,
        FAULT_MOTOR       = 3'd4,
        FAULT_OVERCURRENT = 3'd5,
        FAULT_WATCHDOG    = 3'd6
    } fault_code_t;

    // debouncer result for one tick
    typedef struct packed {
        logic level;
        logic rise;
        logic fall;
    } dbn_out_t;

    // fault register working copy
    typedef struct packed {
        fault_code_t code;
        logic        latch;
        tally_t      tally;
        logic        set;
        logic        clr;
    } fault_st_t;

    function automatic timer_t sat_inc(timer_t v);
        return (&v) ? v : v + timer_t'(1);
    endfunction

    function automatic fault_st_t fault_raise(fault_st_t s, fault_code_t code);
        fault_st_t r;
        r = s;
        if (s.code != code) begin
            r.code  = code;
            r.latch = 1'b1;
            if (s.tally != TALLY_MAX) begin
                r.tally = s.tally + tally_t'(1);
            end
            r.set = 1'b1;
        end
        return r;
    endfunction

    function automatic fault_st_t fault_drop(fault_st_t s);
        fault_st_t r;
        r = s;
        if (s.code != FAULT_NONE) begin
            r.code  = FAULT_NONE;
            r.latch = 1'b0;
            r.clr   = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gss_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_debounce
// Sticky-timer debouncer for one contact: a raw level must stay unchanged
// for the programmed number of ticks before it becomes the accepted level.
// ----------------------------------------------------------------------------
module gss_debounce (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              raw,
    input  gss_pkg::cfg_t     need,
    output gss_pkg::dbn_out_t result
);
    import gss_pkg::*;

    logic   pending_reg;
    logic   accepted_reg;
    timer_t stable_reg;

    logic   diff;
    logic   take;
    timer_t stable_inc;
    timer_t stable_next;
    logic   accepted_next;

    // compare against the settled level and the hold count
    always_comb
    begin
        diff          = raw != pending_reg;
        stable_inc    = sat_inc(stable_reg);
        take          = !diff && (raw != accepted_reg) &&
                        (CMP_W'(stable_inc) >= CMP_W'(need));
        stable_next   = diff ? '0 : stable_inc;
        accepted_next = take ? raw : accepted_reg;
        result.level  = accepted_next;
        result.rise   = take && raw;
        result.fall   = take && !raw;
    end

    // channel state, advanced once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            accepted_reg <= 1'b0;
            stable_reg   <= '0;
        end
        else if (step)
        begin
            pending_reg  <= raw;
            accepted_reg <= accepted_next;
            stable_reg   <= stable_next;
        end
    end

endmodule

>>> hw/rtl/gate_safety_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_safety_supervisor
// Debounced safety interlock with watchdog: one tick item in, one status
// result out, driving a single fault register with set and clear rules.
// Each tick passes the tick register, then the result register; the rule
// chain is combinational, and a tick waits while the result channel stalls.
// Throughput: one tick per cycle while the result channel does not stall.
// Reset: all tick state and counters clear, watchdog starts alive, config
// registers take their default values; no item is held.
// ----------------------------------------------------------------------------
module gate_safety_supervisor (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  gss_pkg::reg_idx_t    cfg_index,
    input  gss_pkg::cfg_t        cfg_data,
    // tick channel
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 obstacle_raw,
    input  logic                 open_end_raw,
    input  logic                 close_end_raw,
    input  logic                 stop_raw,
    input  logic                 motor_fault_in,
    input  logic                 telemetry_valid,
    input  logic [15:0]          current_ma,
    input  logic                 watchdog_feed,
    // result channel
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [2:0]           fault_code,
    output logic                 fault_latched,
    output logic                 safe_to_move,
    output logic                 obstacle_state,
    output logic                 open_end_state,
    output logic                 close_end_state,
    output logic                 stop_state,
    output logic                 watchdog_good,
    output logic [6:0]           event_flags,
    output logic [15:0]          faults_seen,
    output logic [15:0]          obstacle_hits
);
    import gss_pkg::*;

    // configuration registers
    cfg_t obstacle_db_reg;
    cfg_t limit_db_reg;
    cfg_t stop_db_reg;
    cfg_t oc_threshold_reg;
    cfg_t oc_hold_reg;
    cfg_t wd_timeout_reg;

    // tick register
    logic        tick_valid_reg;
    logic        obstacle_raw_reg;
    logic        open_end_raw_reg;
    logic        close_end_raw_reg;
    logic        stop_raw_reg;
    logic        motor_fault_reg;
    logic        telemetry_valid_reg;
    logic [15:0] current_reg;
    logic        feed_reg;

    // supervisor state
    fault_code_t active_fault_reg;
    logic        latch_reg;
    tally_t      fault_tally_reg;
    logic        wd_alive_reg;
    timer_t      since_feed_reg;
    logic        oc_running_reg;
    timer_t      oc_ticks_reg;
    tally_t      obstacle_tally_reg;

    // result register
    logic        result_valid_reg;
    fault_code_t res_fault_reg;
    logic        res_latch_reg;
    logic        res_safe_reg;
    logic        res_obstacle_reg;
    logic        res_open_reg;
    logic        res_close_reg;
    logic        res_stop_reg;
    logic        res_wd_good_reg;
    event_t      res_events_reg;
    tally_t      res_faults_reg;
    tally_t      res_hits_reg;

    // next values
    fault_st_t   fault_next;
    logic        wd_alive_next;
    timer_t      since_feed_next;
    logic        oc_running_next;
    timer_t      oc_ticks_next;
    tally_t      obstacle_tally_next;
    event_t      events_next;
    logic        conflict;
    logic        safe_next;

    logic        advance;
    dbn_out_t    obs_db;
    dbn_out_t    open_db;
    dbn_out_t    close_db;
    dbn_out_t    stop_db;

    // handshakes
    assign advance    = tick_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !tick_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_db_reg  <= RST_OBSTACLE_DB;
            limit_db_reg     <= RST_LIMIT_DB;
            stop_db_reg      <= RST_STOP_DB;
            oc_threshold_reg <= RST_OC_THRESHOLD;
            oc_hold_reg      <= RST_OC_HOLD;
            wd_timeout_reg   <= RST_WD_TIMEOUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OBSTACLE_DB:  obstacle_db_reg  <= cfg_data;
                REG_LIMIT_DB:     limit_db_reg     <= cfg_data;
                REG_STOP_DB:      stop_db_reg      <= cfg_data;
                REG_OC_THRESHOLD: oc_threshold_reg <= cfg_data;
                REG_OC_HOLD:      oc_hold_reg      <= cfg_data;
                REG_WD_TIMEOUT:   wd_timeout_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // tick register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            tick_valid_reg <= item_valid;
        end
    end

    // tick register payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            obstacle_raw_reg    <= obstacle_raw;
            open_end_raw_reg    <= open_end_raw;
            close_end_raw_reg   <= close_end_raw;
            stop_raw_reg        <= stop_raw;
            motor_fault_reg     <= motor_fault_in;
            telemetry_valid_reg <= telemetry_valid;
            current_reg         <= current_ma;
            feed_reg            <= watchdog_feed;
        end
    end

    // contact debouncers
    gss_debounce u_obs_db (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .raw    (obstacle_raw_reg),
        .need   (obstacle_db_reg),
        .result (obs_db)
    );

    gss_debounce u_open_db (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .raw    (open_end_raw_reg),
        .need   (limit_db_reg),
        .result (open_db)
    );

    gss_debounce u_close_db (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .raw    (close_end_raw_reg),
        .need   (limit_db_reg),
        .result (close_db)
    );

    gss_debounce u_stop_db (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .raw    (stop_raw_reg),
        .need   (stop_db_reg),
        .result (stop_db)
    );

    // fault rules in fixed order
    always_comb
    begin
        fault_next.code     = active_fault_reg;
        fault_next.latch    = latch_reg;
        fault_next.tally    = fault_tally_reg;
        fault_next.set      = 1'b0;
        fault_next.clr      = 1'b0;
        obstacle_tally_next = obstacle_tally_reg;
        wd_alive_next       = wd_alive_reg;
        since_feed_next     = since_feed_reg;
        oc_running_next     = oc_running_reg;
        oc_ticks_next       = oc_ticks_reg;
        events_next         = '0;

        // obstacle edges
        if (obs_db.rise)
        begin
            if (obstacle_tally_reg != TALLY_MAX)
            begin
                obstacle_tally_next = obstacle_tally_reg + tally_t'(1);
            end
            events_next[EV_OBS_ON] = 1'b1;
            fault_next = fault_raise(fault_next, FAULT_OBSTACLE);
        end
        else if (obs_db.fall)
        begin
            events_next[EV_OBS_OFF] = 1'b1;
            if (fault_next.code == FAULT_OBSTACLE)
            begin
                fault_next = fault_drop(fault_next);
            end
        end
        events_next[EV_OPEN]  = open_db.rise;
        events_next[EV_CLOSE] = close_db.rise;
        events_next[EV_STOP]  = stop_db.rise;

        // motor driver
        if (motor_fault_reg && fault_next.code == FAULT_NONE)
        begin
            fault_next = fault_raise(fault_next, FAULT_MOTOR);
        end
        else if (!motor_fault_reg && fault_next.code == FAULT_MOTOR)
        begin
            fault_next = fault_drop(fault_next);
        end

        // telemetry link
        if (!telemetry_valid_reg && fault_next.code == FAULT_NONE)
        begin
            fault_next = fault_raise(fault_next, FAULT_TELEMETRY);
        end
        else if (telemetry_valid_reg && fault_next.code == FAULT_TELEMETRY)
        begin
            fault_next = fault_drop(fault_next);
        end

        // overcurrent duration
        if (current_reg >= oc_threshold_reg)
        begin
            if (!oc_running_reg)
            begin
                oc_running_next = 1'b1;
                oc_ticks_next   = '0;
            end
            else
            begin
                oc_ticks_next = sat_inc(oc_ticks_reg);
                if (CMP_W'(oc_ticks_next) >= CMP_W'(oc_hold_reg))
                begin
                    fault_next = fault_raise(fault_next, FAULT_OVERCURRENT);
                end
            end
        end
        else
        begin
            oc_running_next = 1'b0;
        end

        // watchdog feed
        if (feed_reg)
        begin
            since_feed_next = '0;
            if (!wd_alive_reg)
            begin
                wd_alive_next = 1'b1;
                fault_next    = fault_drop(fault_next);
            end
        end
        else
        begin
            since_feed_next = sat_inc(since_feed_reg);
        end

        // watchdog timeout
        if (!wd_alive_next && (CMP_W'(since_feed_next) < CMP_W'(wd_timeout_reg)))
        begin
            wd_alive_next = 1'b1;
            fault_next    = fault_drop(fault_next);
        end
        else if (wd_alive_next && (CMP_W'(since_feed_next) >= CMP_W'(wd_timeout_reg)))
        begin
            wd_alive_next = 1'b0;
            fault_next    = fault_raise(fault_next, FAULT_WATCHDOG);
        end

        // end switch conflict
        conflict = open_db.level && close_db.level;
        if (conflict && fault_next.code == FAULT_NONE)
        begin
            fault_next = fault_raise(fault_next, FAULT_LIMIT);
        end
        else if (!conflict && fault_next.code == FAULT_LIMIT)
        begin
            fault_next = fault_drop(fault_next);
        end

        events_next[EV_SET]   = fault_next.set;
        events_next[EV_CLEAR] = fault_next.clr;

        safe_next = (fault_next.code == FAULT_NONE) && !obs_db.level &&
                    !stop_db.level && wd_alive_next && !conflict;
    end

    // supervisor state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_fault_reg   <= FAULT_NONE;
            latch_reg          <= 1'b0;
            fault_tally_reg    <= '0;
            wd_alive_reg       <= 1'b1;
            since_feed_reg     <= '0;
            oc_running_reg     <= 1'b0;
            oc_ticks_reg       <= '0;
            obstacle_tally_reg <= '0;
        end
        else if (advance)
        begin
            active_fault_reg   <= fault_next.code;
            latch_reg          <= fault_next.latch;
            fault_tally_reg    <= fault_next.tally;
            wd_alive_reg       <= wd_alive_next;
            since_feed_reg     <= since_feed_next;
            oc_running_reg     <= oc_running_next;
            oc_ticks_reg       <= oc_ticks_next;
            obstacle_tally_reg <= obstacle_tally_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_fault_reg    <= fault_next.code;
            res_latch_reg    <= fault_next.latch;
            res_safe_reg     <= safe_next;
            res_obstacle_reg <= obs_db.level;
            res_open_reg     <= open_db.level;
            res_close_reg    <= close_db.level;
            res_stop_reg     <= stop_db.level;
            res_wd_good_reg  <= wd_alive_next;
            res_events_reg   <= events_next;
            res_faults_reg   <= fault_next.tally;
            res_hits_reg     <= obstacle_tally_next;
        end
    end

    // result ports
    assign result_valid    = result_valid_reg;
    assign fault_code      = res_fault_reg;
    assign fault_latched   = res_latch_reg;
    assign safe_to_move    = res_safe_reg;
    assign obstacle_state  = res_obstacle_reg;
    assign open_end_state  = res_open_reg;
    assign close_end_state = res_close_reg;
    assign stop_state      = res_stop_reg;
    assign watchdog_good   = res_wd_good_reg;
    assign event_flags     = res_events_reg;
    assign faults_seen     = res_faults_reg;
    assign obstacle_hits   = res_hits_reg;

endmodule

>>> dv/gss_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_status_checker
// Watches the configuration, tick and status channels of the gate safety
// supervisor. Every tick transfer is run through a local model of the
// debouncers, fault rules and watchdog, and the expected status word is
// queued. Every status transfer is compared field by field against the
// oldest queued status word.
// ----------------------------------------------------------------------------
module gss_status_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  gss_pkg::reg_idx_t  cfg_index,
    input  gss_pkg::cfg_t      cfg_data,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic               obstacle_raw,
    input  logic               open_end_raw,
    input  logic               close_end_raw,
    input  logic               stop_raw,
    input  logic               motor_fault_in,
    input  logic               telemetry_valid,
    input  logic [15:0]        current_ma,
    input  logic               watchdog_feed,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic [2:0]         fault_code,
    input  logic               fault_latched,
    input  logic               safe_to_move,
    input  logic               obstacle_state,
    input  logic               open_end_state,
    input  logic               close_end_state,
    input  logic               stop_state,
    input  logic               watchdog_good,
    input  logic [6:0]         event_flags,
    input  logic [15:0]        faults_seen,
    input  logic [15:0]        obstacle_hits,
    output int unsigned        mismatch_count,
    output int unsigned        results_due
);
    import gss_pkg::*;

    localparam int CH_OBSTACLE  = 0;
    localparam int CH_OPEN_END  = 1;
    localparam int CH_CLOSE_END = 2;
    localparam int CH_STOP      = 3;

    typedef struct packed {
        fault_code_t code;
        logic        latched;
        logic        safe;
        logic        obstacle;
        logic        open_end;
        logic        close_end;
        logic        stop;
        logic        wd_good;
        event_t      events;
        tally_t      faults;
        tally_t      hits;
    } status_t;

    // register copies
    cfg_t db_obstacle;
    cfg_t db_limit;
    cfg_t db_stop;
    cfg_t oc_threshold;
    cfg_t oc_hold;
    cfg_t wd_timeout;

    // supervisor state copy
    logic        pend [4];
    logic        level [4];
    timer_t      steady [4];
    fault_code_t fault_now;
    logic        latch_now;
    tally_t      fault_count;
    tally_t      obstacle_count;
    logic        wd_alive;
    timer_t      since_feed;
    logic        oc_active;
    timer_t      oc_count;
    event_t      ev;

    status_t     status_due [$];
    int unsigned results_checked;

    initial begin
        mismatch_count  = 0;
        results_checked = 0;
    end

    function automatic timer_t timer_step(timer_t v);
        return (v == '1) ? v : timer_t'(v + 1'b1);
    endfunction

    task automatic set_fault(fault_code_t code);
        if (fault_now != code) begin
            fault_now = code;
            latch_now = 1'b1;
            if (fault_count != '1) begin
                fault_count = fault_count + 1'b1;
            end
            ev[EV_SET] = 1'b1;
        end
    endtask

    task automatic clear_fault();
        if (fault_now != FAULT_NONE) begin
            fault_now = FAULT_NONE;
            latch_now = 1'b0;
            ev[EV_CLEAR] = 1'b1;
        end
    endtask

    // sticky-timer debouncer for one contact
    task automatic debounce_step(input int ch, input logic raw, input cfg_t need,
                                 output logic rose, output logic fell);
        rose = 1'b0;
        fell = 1'b0;
        if (raw != pend[ch]) begin
            pend[ch]   = raw;
            steady[ch] = '0;
        end
        else begin
            steady[ch] = timer_step(steady[ch]);
            if (raw != level[ch] && steady[ch] >= need) begin
                level[ch] = raw;
                rose      = raw;
                fell      = !raw;
            end
        end
    endtask

    // one millisecond tick of the supervisor, rules in their fixed order
    task automatic advance_supervisor(output status_t s);
        logic rose;
        logic fell;
        logic conflict;
        ev = '0;

        debounce_step(CH_OBSTACLE, obstacle_raw, db_obstacle, rose, fell);
        if (rose) begin
            if (obstacle_count != '1) begin
                obstacle_count = obstacle_count + 1'b1;
            end
            ev[EV_OBS_ON] = 1'b1;
            set_fault(FAULT_OBSTACLE);
        end
        else if (fell) begin
            ev[EV_OBS_OFF] = 1'b1;
            if (fault_now == FAULT_OBSTACLE) begin
                clear_fault();
            end
        end
        debounce_step(CH_OPEN_END, open_end_raw, db_limit, rose, fell);
        if (rose) begin
            ev[EV_OPEN] = 1'b1;
        end
        debounce_step(CH_CLOSE_END, close_end_raw, db_limit, rose, fell);
        if (rose) begin
            ev[EV_CLOSE] = 1'b1;
        end
        debounce_step(CH_STOP, stop_raw, db_stop, rose, fell);
        if (rose) begin
            ev[EV_STOP] = 1'b1;
        end

        // motor and telemetry rules only own their own fault
        if (motor_fault_in && fault_now == FAULT_NONE) begin
            set_fault(FAULT_MOTOR);
        end
        else if (!motor_fault_in && fault_now == FAULT_MOTOR) begin
            clear_fault();
        end
        if (!telemetry_valid && fault_now == FAULT_NONE) begin
            set_fault(FAULT_TELEMETRY);
        end
        else if (telemetry_valid && fault_now == FAULT_TELEMETRY) begin
            clear_fault();
        end

        // overcurrent duration, first high tick starts at zero
        if (current_ma >= oc_threshold) begin
            if (!oc_active) begin
                oc_active = 1'b1;
                oc_count  = '0;
            end
            else begin
                oc_count = timer_step(oc_count);
                if (oc_count >= oc_hold) begin
                    set_fault(FAULT_OVERCURRENT);
                end
            end
        end
        else begin
            oc_active = 1'b0;
        end

        // feed, a restoring feed also clears the fault
        if (watchdog_feed) begin
            since_feed = '0;
            if (!wd_alive) begin
                wd_alive = 1'b1;
                clear_fault();
            end
        end
        else begin
            since_feed = timer_step(since_feed);
        end

        // timeout, or recovery after the timeout was raised
        if (!wd_alive && since_feed < wd_timeout) begin
            wd_alive = 1'b1;
            clear_fault();
        end
        else if (wd_alive && since_feed >= wd_timeout) begin
            wd_alive = 1'b0;
            set_fault(FAULT_WATCHDOG);
        end

        conflict = level[CH_OPEN_END] && level[CH_CLOSE_END];
        if (conflict && fault_now == FAULT_NONE) begin
            set_fault(FAULT_LIMIT);
        end
        else if (!conflict && fault_now == FAULT_LIMIT) begin
            clear_fault();
        end

        s.code      = fault_now;
        s.latched   = latch_now;
        s.safe      = fault_now == FAULT_NONE && !level[CH_OBSTACLE] && !level[CH_STOP]
                      && wd_alive && !conflict;
        s.obstacle  = level[CH_OBSTACLE];
        s.open_end  = level[CH_OPEN_END];
        s.close_end = level[CH_CLOSE_END];
        s.stop      = level[CH_STOP];
        s.wd_good   = wd_alive;
        s.events    = ev;
        s.faults    = fault_count;
        s.hits      = obstacle_count;
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] status %0d: %s", $realtime, results_checked, what);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // channel monitor: config, then status compare, then tick prediction
    always @(posedge clk or negedge rst_n) begin : monitor
        status_t want;
        if (!rst_n) begin
            db_obstacle    = RST_OBSTACLE_DB;
            db_limit       = RST_LIMIT_DB;
            db_stop        = RST_STOP_DB;
            oc_threshold   = RST_OC_THRESHOLD;
            oc_hold        = RST_OC_HOLD;
            wd_timeout     = RST_WD_TIMEOUT;
            for (int i = 0; i < 4; i++) begin
                pend[i]   = 1'b0;
                level[i]  = 1'b0;
                steady[i] = '0;
            end
            fault_now      = FAULT_NONE;
            latch_now      = 1'b0;
            fault_count    = '0;
            obstacle_count = '0;
            wd_alive       = 1'b1;
            since_feed     = '0;
            oc_active      = 1'b0;
            oc_count       = '0;
            status_due.delete();
            results_due   <= 0;
        end
        else begin
            // register write transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OBSTACLE_DB:  db_obstacle  = cfg_data;
                    REG_LIMIT_DB:     db_limit     = cfg_data;
                    REG_STOP_DB:      db_stop      = cfg_data;
                    REG_OC_THRESHOLD: oc_threshold = cfg_data;
                    REG_OC_HOLD:      oc_hold      = cfg_data;
                    REG_WD_TIMEOUT:   wd_timeout   = cfg_data;
                    default: ;
                endcase
            end

            // status transfer
            if (result_valid && result_ready) begin
                if (status_due.size() == 0) begin
                    report_mismatch("status transfer with nothing outstanding");
                end
                else begin
                    want = status_due.pop_front();
                    check_field("fault_code", 16'(fault_code), 16'(want.code));
                    check_field("fault_latched", 16'(fault_latched), 16'(want.latched));
                    check_field("safe_to_move", 16'(safe_to_move), 16'(want.safe));
                    check_field("obstacle_state", 16'(obstacle_state), 16'(want.obstacle));
                    check_field("open_end_state", 16'(open_end_state), 16'(want.open_end));
                    check_field("close_end_state", 16'(close_end_state),
                                16'(want.close_end));
                    check_field("stop_state", 16'(stop_state), 16'(want.stop));
                    check_field("watchdog_good", 16'(watchdog_good), 16'(want.wd_good));
                    check_field("event_flags", 16'(event_flags), 16'(want.events));
                    check_field("faults_seen", faults_seen, want.faults);
                    check_field("obstacle_hits", obstacle_hits, want.hits);
                end
                results_checked = results_checked + 1;
            end

            // tick transfer
            if (item_valid && item_ready) begin
                advance_supervisor(want);
                status_due.push_back(want);
            end

            results_due <= status_due.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the gate safety supervisor. A short directed
// run covers the fault rules and input extremes, then several register
// settings are each exercised with sticky, mostly stable contact levels,
// occasional glitches and currents around the threshold. Both channels idle
// at random; the status side holds off once long enough to back up the block.
// ----------------------------------------------------------------------------
module testbench;
    import gss_pkg::*;

    localparam reg_idx_t    REG_SPARE_LO   = 3'd6;
    localparam reg_idx_t    REG_SPARE_HI   = 3'd7;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned TICKS_PER_PHASE = 55;
    localparam int unsigned CHOKE_CYCLES   = 300;
    localparam int unsigned QUIET_LIMIT    = 5000;

    typedef struct packed {
        logic        obstacle;
        logic        open_end;
        logic        close_end;
        logic        stop;
        logic        motor;
        logic        telem;
        logic [15:0] current;
        logic        feed;
    } tick_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    reg_idx_t    cfg_index;
    cfg_t        cfg_data;
    logic        item_valid;
    logic        item_ready;
    logic        obstacle_raw;
    logic        open_end_raw;
    logic        close_end_raw;
    logic        stop_raw;
    logic        motor_fault_in;
    logic        telemetry_valid;
    logic [15:0] current_ma;
    logic        watchdog_feed;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  fault_code;
    logic        fault_latched;
    logic        safe_to_move;
    logic        obstacle_state;
    logic        open_end_state;
    logic        close_end_state;
    logic        stop_state;
    logic        watchdog_good;
    logic [6:0]  event_flags;
    logic [15:0] faults_seen;
    logic [15:0] obstacle_hits;

    int unsigned mismatch_count;
    int unsigned results_due;
    int unsigned quiet_cycles = 0;

    // stimulus shaping shared with the status side
    logic calm          = 1'b0;
    logic rush          = 1'b0;
    logic choke_request = 1'b0;
    cfg_t threshold_now = RST_OC_THRESHOLD;

    always #5 clk = ~clk;

    gate_safety_supervisor DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .obstacle_raw    (obstacle_raw),
        .open_end_raw    (open_end_raw),
        .close_end_raw   (close_end_raw),
        .stop_raw        (stop_raw),
        .motor_fault_in  (motor_fault_in),
        .telemetry_valid (telemetry_valid),
        .current_ma      (current_ma),
        .watchdog_feed   (watchdog_feed),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .fault_code      (fault_code),
        .fault_latched   (fault_latched),
        .safe_to_move    (safe_to_move),
        .obstacle_state  (obstacle_state),
        .open_end_state  (open_end_state),
        .close_end_state (close_end_state),
        .stop_state      (stop_state),
        .watchdog_good   (watchdog_good),
        .event_flags     (event_flags),
        .faults_seen     (faults_seen),
        .obstacle_hits   (obstacle_hits)
    );

    gss_status_checker status_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .obstacle_raw    (obstacle_raw),
        .open_end_raw    (open_end_raw),
        .close_end_raw   (close_end_raw),
        .stop_raw        (stop_raw),
        .motor_fault_in  (motor_fault_in),
        .telemetry_valid (telemetry_valid),
        .current_ma      (current_ma),
        .watchdog_feed   (watchdog_feed),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .fault_code      (fault_code),
        .fault_latched   (fault_latched),
        .safe_to_move    (safe_to_move),
        .obstacle_state  (obstacle_state),
        .open_end_state  (open_end_state),
        .close_end_state (close_end_state),
        .stop_state      (stop_state),
        .watchdog_good   (watchdog_good),
        .event_flags     (event_flags),
        .faults_seen     (faults_seen),
        .obstacle_hits   (obstacle_hits),
        .mismatch_count  (mismatch_count),
        .results_due     (results_due)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 80) begin
            return $urandom_range(3, 1);
        end
        else if (pick < 95) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // offer one tick, held until the transfer
    task automatic offer_tick(tick_t t);
        if (!calm && !rush && $urandom_range(2, 0) == 0) begin
            item_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        item_valid      <= 1'b1;
        obstacle_raw    <= t.obstacle;
        open_end_raw    <= t.open_end;
        close_end_raw   <= t.close_end;
        stop_raw        <= t.stop;
        motor_fault_in  <= t.motor;
        telemetry_valid <= t.telem;
        current_ma      <= t.current;
        watchdog_feed   <= t.feed;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // stop offering and wait until every status word has come back
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_reg(reg_idx_t idx, cfg_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // write every register, plus one write to an unmapped index
    task automatic program_settings(cfg_t obs_db, cfg_t lim_db, cfg_t stop_db,
                                    cfg_t thr, cfg_t hold, cfg_t wd);
        write_reg($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, cfg_t'($urandom));
        write_reg(REG_OBSTACLE_DB, obs_db);
        write_reg(REG_LIMIT_DB, lim_db);
        write_reg(REG_STOP_DB, stop_db);
        write_reg(REG_OC_THRESHOLD, thr);
        write_reg(REG_OC_HOLD, hold);
        write_reg(REG_WD_TIMEOUT, wd);
        cfg_valid     <= 1'b0;
        threshold_now  = thr;
    endtask

    // status side: random stalls, one long hold-off on request
    initial begin
        int unsigned stall_left;
        logic        choke_done;
        stall_left    = 0;
        choke_done    = 1'b0;
        result_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (choke_request && !choke_done) begin
                result_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_done = 1'b1;
            end
            else if (stall_left != 0) begin
                result_ready <= 1'b0;
                stall_left    = stall_left - 1;
            end
            else if (!calm && $urandom_range(3, 0) == 0) begin
                result_ready <= 1'b0;
                stall_left    = gap_len() - 1;
            end
            else begin
                result_ready <= 1'b1;
            end
        end
    end

    // hang detection: cycles without any transfer
    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // main stimulus
    initial begin
        tick_t       t;
        logic [3:0]  contacts_held;
        logic [3:0]  glitch;
        logic        motor_held;
        logic        telem_held;
        logic        oc_high;

        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_OBSTACLE_DB;
        cfg_data        <= '0;
        item_valid      <= 1'b0;
        obstacle_raw    <= 1'b0;
        open_end_raw    <= 1'b0;
        close_end_raw   <= 1'b0;
        stop_raw        <= 1'b0;
        motor_fault_in  <= 1'b0;
        telemetry_valid <= 1'b0;
        current_ma      <= '0;
        watchdog_feed   <= 1'b0;
        contacts_held    = '0;
        motor_held       = 1'b0;
        telem_held       = 1'b1;
        oc_high          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: telemetry, motor and overcurrent rules, field extremes
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd9999, 1'b0});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd10000, 1'b0});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b1});
        offer_tick('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1, 1'b0});
        offer_tick('{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd2, 1'b0});
        offer_tick('{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd4, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'h8000, 1'b0});
        offer_tick('{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1});
        offer_tick('{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'hAAAA, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'h5555, 1'b0});
        wait_for_results();

        // zero debounce: obstacle edges, fault replacement, watchdog loss,
        // recovery by feed, end-switch conflict
        program_settings(16'd0, 16'd0, 16'd0, 16'd1000, 16'd1, 16'd2);
        offer_tick('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1000, 1'b1});
        offer_tick('{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd1000, 1'b1});
        offer_tick('{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd999, 1'b1});
        offer_tick('{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0});
        offer_tick('{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0});
        offer_tick('{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 1'b0});
        offer_tick('{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1});
        offer_tick('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1});
        wait_for_results();

        // random phases, one register setting each
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_settings(16'd0, 16'd0, 16'd0, cfg_t'($urandom_range(3000, 0)),
                                    16'd0, 16'd0);
                1: program_settings(16'd1, 16'd2, 16'd3, 16'd0, 16'd3,
                                    cfg_t'($urandom_range(8, 2)));
                2: program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF);
                4: program_settings(16'd0, 16'd1, 16'd0, cfg_t'($urandom),
                                    cfg_t'($urandom_range(2, 0)),
                                    cfg_t'($urandom_range(6, 1)));
                5: program_settings(cfg_t'($urandom_range(20, 5)),
                                    cfg_t'($urandom_range(20, 5)),
                                    cfg_t'($urandom_range(20, 5)), cfg_t'($urandom),
                                    cfg_t'($urandom_range(8, 0)),
                                    cfg_t'($urandom_range(40, 10)));
                default: program_settings(cfg_t'($urandom_range(4, 0)),
                                          cfg_t'($urandom_range(4, 0)),
                                          cfg_t'($urandom_range(4, 0)),
                                          cfg_t'($urandom_range(5000, 500)),
                                          cfg_t'($urandom_range(5, 0)),
                                          cfg_t'($urandom_range(10, 3)));
            endcase
            calm = (phase == 5);
            rush = (phase == 3);
            if (phase == 3) begin
                choke_request = 1'b1;
            end

            for (int unsigned n = 0; n < TICKS_PER_PHASE; n++) begin
                // contacts hold their level for a while, with the odd glitch
                for (int i = 0; i < 4; i++) begin
                    if ($urandom_range(9, 0) == 0) begin
                        contacts_held[i] = !contacts_held[i];
                    end
                    glitch[i] = ($urandom_range(19, 0) == 0);
                end
                if ($urandom_range(14, 0) == 0) begin
                    motor_held = !motor_held;
                end
                if ($urandom_range(14, 0) == 0) begin
                    telem_held = !telem_held;
                end
                if ($urandom_range(7, 0) == 0) begin
                    oc_high = !oc_high;
                end
                t.obstacle  = contacts_held[0] ^ glitch[0];
                t.open_end  = contacts_held[1] ^ glitch[1];
                t.close_end = contacts_held[2] ^ glitch[2];
                t.stop      = contacts_held[3] ^ glitch[3];
                t.motor     = motor_held;
                t.telem     = telem_held;
                if ($urandom_range(9, 0) == 0) begin
                    t.current = 16'($urandom);
                end
                else if (oc_high) begin
                    t.current = 16'($urandom_range(65535, threshold_now));
                end
                else if (threshold_now == 0) begin
                    t.current = '0;
                end
                else begin
                    t.current = 16'($urandom_range(threshold_now - 1, 0));
                end
                t.feed = ($urandom_range(3, 0) == 0);
                offer_tick(t);
            end
            wait_for_results();
        end
        calm = 1'b0;
        rush = 1'b0;

        // let any stray status word surface before the verdict
        repeat (4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
